### hdl/dle_pkg.sv
// Shared constants for the dominator and loop-depth engine.
// Used by the top level and by the port checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dle_pkg;
   localparam int MAX_BLOCKS_DEF = 64;
   localparam int LABEL_W        = 6;
   localparam int COUNT_W        = 7;
   localparam int DEPTH_W        = 13;
   localparam int SET_W          = 64;
   localparam int CMD_W          = 2;

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic REG_BLOCK_COUNT = 1'b0;
   localparam logic REG_ENTRY_BLOCK = 1'b1;

   localparam logic [DEPTH_W-1:0] DEPTH_SAT = 13'd4096;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
endpackage
`default_nettype wire

### hdl/dle_ram.sv
// Simple one-write, one-read memory with registered read data.
// Self-contained; no package needed.
`timescale 1ns / 1ps
`default_nettype none
module dle_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### hdl/dominator_loop_depth_engine.sv
// A run does an init pass, then the dominator fixpoint passes (one stored row per cycle
// through the dominator memory port), then the back-edge scan over every block pair and
// edge; each back edge adds natural-loop walk passes and a depth counter sweep. Result
// beats then follow, one beat per cycle, labels ascending; the receiver cannot stall,
// and a new command is taken on the final beat.
// Reset clears edges (row valid bits), config to 64 blocks / entry 0; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module dominator_loop_depth_engine #(
   parameter int MAX_BLOCKS = dle_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [dle_pkg::CMD_W-1:0]       req_cmd,
   input  wire logic [dle_pkg::LABEL_W-1:0]     req_from_block,
   input  wire logic [dle_pkg::LABEL_W-1:0]     req_to_block,
   input  wire logic                            csr_wr_en,
   input  wire logic                            csr_index,
   input  wire logic [dle_pkg::COUNT_W-1:0]     csr_wr_data,
   output logic                                 rsp_valid,
   output logic [dle_pkg::LABEL_W-1:0]          rsp_block_label,
   output logic [dle_pkg::SET_W-1:0]            rsp_dominator_set,
   output logic [dle_pkg::DEPTH_W-1:0]          rsp_loop_depth,
   output logic                                 rsp_last
);
   import dle_pkg::*;

   localparam int NB = (MAX_BLOCKS < 64) ? MAX_BLOCKS : 64;
   localparam int AW = $clog2(NB);
   localparam logic [COUNT_W-1:0] NB_C = COUNT_W'(NB);
   localparam logic [NB-1:0] ONE = NB'(1);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_AD_WR   = 4'd1;
   localparam logic [3:0] ST_IN_SCAN = 4'd2;
   localparam logic [3:0] ST_FX_ROW  = 4'd3;
   localparam logic [3:0] ST_FX_WAIT = 4'd4;
   localparam logic [3:0] ST_FX_SCAN = 4'd5;
   localparam logic [3:0] ST_FX_DONE = 4'd6;
   localparam logic [3:0] ST_LH_ROW  = 4'd7;
   localparam logic [3:0] ST_LH_WAIT = 4'd8;
   localparam logic [3:0] ST_LT_TEST = 4'd9;
   localparam logic [3:0] ST_LT_CHK  = 4'd10;
   localparam logic [3:0] ST_WK_SCAN = 4'd11;
   localparam logic [3:0] ST_WK_DRN  = 4'd12;
   localparam logic [3:0] ST_DP_SCAN = 4'd13;
   localparam logic [3:0] ST_DP_DRN  = 4'd14;
   localparam logic [3:0] ST_EM_SCAN = 4'd15;

   logic [3:0]         state_ff, state_in;
   logic [AW-1:0]      row_ff, row_in, col_ff, col_in, scan_ff, scan_in, prev_ff, prev_in;
   logic               changed_ff, changed_in;
   logic [NB-1:0]      rowp_ff, rowp_in, acc_ff, acc_in, old_ff, old_in;
   logic [NB-1:0]      member_ff, member_in, pend_ff, pend_in;
   logic               flag_ff, flag_in, dflag_ff, dflag_in;
   logic               out_v_ff, out_v_in, out_last_ff, out_last_in;
   logic [AW-1:0]      out_lbl_ff, out_lbl_in;
   logic [NB-1:0]      pvalid_ff, pvalid_in;
   logic               prd_valid_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [LABEL_W-1:0] entry_ff;

   logic               pr_wr_en, dm_wr_en, dp_wr_en;
   logic [AW-1:0]      pr_wr_addr, pr_rd_addr, dm_wr_addr, dm_rd_addr, dp_wr_addr, dp_rd_addr;
   logic [NB-1:0]      pr_wr_data, pr_rd_data, dm_wr_data, dm_rd_data;
   logic [DEPTH_W-1:0] dp_wr_data, dp_rd_data;

   logic [COUNT_W-1:0] eff;
   logic [AW-1:0]      last_idx;
   logic               entry_ok;
   logic [NB-1:0]      low_mask, pred_row, pred_masked, acc_next, nw, pend_base, nm;
   logic               chg;

   always_comb begin
      if (count_ff == '0) begin
         eff = COUNT_W'(1);
      end else if (count_ff > NB_C) begin
         eff = NB_C;
      end else begin
         eff = count_ff;
      end
   end
   assign last_idx = AW'(eff - COUNT_W'(1));
   assign entry_ok = {1'b0, entry_ff} < eff;

   always_comb begin
      for (int i = 0; i < NB; i++) begin
         low_mask[i] = (AW'(i) <= last_idx);
      end
   end

   assign pred_row    = prd_valid_ff ? pr_rd_data : '0;
   assign pred_masked = pred_row & low_mask;
   assign acc_next    = flag_ff ? (acc_ff & dm_rd_data) : acc_ff;
   assign nw          = flag_ff ? (pred_masked & ~member_ff) : '0;
   assign pend_base   = pend_ff | nw;
   assign nm          = ((|rowp_ff) ? acc_next : '0) | (ONE << row_ff);
   assign chg         = changed_ff | (nm != old_ff);

   dle_ram #(.DEPTH(NB), .WIDTH(NB)) u_pred (
      .clock(clock), .wr_en(pr_wr_en), .wr_addr(pr_wr_addr), .wr_data(pr_wr_data),
      .rd_addr(pr_rd_addr), .rd_data(pr_rd_data)
   );
   dle_ram #(.DEPTH(NB), .WIDTH(NB)) u_dom (
      .clock(clock), .wr_en(dm_wr_en), .wr_addr(dm_wr_addr), .wr_data(dm_wr_data),
      .rd_addr(dm_rd_addr), .rd_data(dm_rd_data)
   );
   dle_ram #(.DEPTH(NB), .WIDTH(DEPTH_W)) u_depth (
      .clock(clock), .wr_en(dp_wr_en), .wr_addr(dp_wr_addr), .wr_data(dp_wr_data),
      .rd_addr(dp_rd_addr), .rd_data(dp_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      scan_in     = scan_ff;
      prev_in     = prev_ff;
      changed_in  = changed_ff;
      rowp_in     = rowp_ff;
      acc_in      = acc_ff;
      old_in      = old_ff;
      member_in   = member_ff;
      pend_in     = pend_ff;
      flag_in     = 1'b0;
      dflag_in    = 1'b0;
      out_v_in    = 1'b0;
      out_last_in = 1'b0;
      out_lbl_in  = out_lbl_ff;
      pvalid_in   = pvalid_ff;
      pr_wr_en    = 1'b0;
      pr_wr_addr  = row_ff;
      pr_wr_data  = pred_row | (ONE << col_ff);
      pr_rd_addr  = row_ff;
      dm_wr_en    = 1'b0;
      dm_wr_addr  = row_ff;
      dm_wr_data  = nm;
      dm_rd_addr  = row_ff;
      dp_wr_en    = dflag_ff;
      dp_wr_addr  = prev_ff;
      dp_wr_data  = (dp_rd_data < DEPTH_SAT) ? dp_rd_data + DEPTH_W'(1) : dp_rd_data;
      dp_rd_addr  = scan_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_cmd)
                  CMD_ADD: begin
                     if ({1'b0, req_from_block} < NB_C && {1'b0, req_to_block} < NB_C) begin
                        row_in     = AW'(req_to_block);
                        col_in     = AW'(req_from_block);
                        pr_rd_addr = AW'(req_to_block);
                        state_in   = ST_AD_WR;
                     end
                  end
                  CMD_CLEAR: pvalid_in = '0;
                  CMD_RUN: begin
                     row_in   = '0;
                     state_in = ST_IN_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_AD_WR: begin
            pr_wr_en          = 1'b1;
            pvalid_in[row_ff] = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_IN_SCAN: begin
            dm_wr_en   = 1'b1;
            dm_wr_data = (entry_ok && entry_ff == LABEL_W'(row_ff)) ? (ONE << row_ff) : low_mask;
            dp_wr_en   = 1'b1;
            dp_wr_addr = row_ff;
            dp_wr_data = '0;
            if (row_ff == last_idx) begin
               row_in     = '0;
               changed_in = 1'b0;
               state_in   = ST_FX_ROW;
            end else begin
               row_in = row_ff + AW'(1);
            end
         end
         ST_FX_ROW, ST_FX_DONE: begin
            if (state_ff == ST_FX_ROW && !(entry_ok && entry_ff == LABEL_W'(row_ff))) begin
               state_in = ST_FX_WAIT;
            end else begin
               // entry row is skipped; finished rows write back and advance
               if (state_ff == ST_FX_DONE) begin
                  dm_wr_en   = 1'b1;
                  changed_in = chg;
               end
               if (row_ff == last_idx) begin
                  row_in = '0;
                  if ((state_ff == ST_FX_DONE) ? chg : changed_ff) begin
                     changed_in = 1'b0;
                     state_in   = ST_FX_ROW;
                  end else begin
                     state_in = ST_LH_ROW;
                  end
               end else begin
                  row_in   = row_ff + AW'(1);
                  state_in = ST_FX_ROW;
               end
            end
         end
         ST_FX_WAIT: begin
            rowp_in  = pred_masked;
            old_in   = dm_rd_data;
            acc_in   = '1;
            col_in   = '0;
            state_in = ST_FX_SCAN;
         end
         ST_FX_SCAN: begin
            dm_rd_addr = col_ff;
            flag_in    = rowp_ff[col_ff];
            acc_in     = acc_next;
            if (col_ff == last_idx) begin
               state_in = ST_FX_DONE;
            end else begin
               col_in = col_ff + AW'(1);
            end
         end
         ST_LH_ROW: state_in = ST_LH_WAIT;
         ST_LH_WAIT: begin
            rowp_in  = pred_masked;
            col_in   = '0;
            state_in = ST_LT_TEST;
         end
         ST_LT_TEST, ST_LT_CHK, ST_DP_DRN: begin
            if (state_ff == ST_LT_TEST && rowp_ff[col_ff]) begin
               dm_rd_addr = col_ff;
               state_in   = ST_LT_CHK;
            end else if (state_ff == ST_LT_CHK && dm_rd_data[row_ff]) begin
               // back edge: seed the natural loop walk
               member_in = (ONE << row_ff) | (ONE << col_ff);
               pend_in   = (col_ff == row_ff) ? '0 : (ONE << col_ff);
               scan_in   = '0;
               state_in  = ST_WK_SCAN;
            end else if (col_ff == last_idx) begin
               col_in = '0;
               if (row_ff == last_idx) begin
                  row_in   = '0;
                  state_in = ST_EM_SCAN;
               end else begin
                  row_in   = row_ff + AW'(1);
                  state_in = ST_LH_ROW;
               end
            end else begin
               col_in   = col_ff + AW'(1);
               state_in = ST_LT_TEST;
            end
         end
         ST_WK_SCAN: begin
            pr_rd_addr = scan_ff;
            flag_in    = pend_ff[scan_ff];
            member_in  = member_ff | nw;
            pend_in    = pend_base & ~(pend_ff[scan_ff] ? (ONE << scan_ff) : '0);
            if (scan_ff == last_idx) begin
               state_in = ST_WK_DRN;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         ST_WK_DRN: begin
            member_in = member_ff | nw;
            pend_in   = pend_base;
            scan_in   = '0;
            state_in  = (pend_base == '0) ? ST_DP_SCAN : ST_WK_SCAN;
         end
         ST_DP_SCAN: begin
            dflag_in = member_ff[scan_ff];
            prev_in  = scan_ff;
            if (scan_ff == last_idx) begin
               state_in = ST_DP_DRN;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         ST_EM_SCAN: begin
            dm_rd_addr  = row_ff;
            dp_rd_addr  = row_ff;
            out_v_in    = 1'b1;
            out_lbl_in  = row_ff;
            out_last_in = (row_ff == last_idx);
            if (row_ff == last_idx) begin
               state_in = ST_IDLE;
            end else begin
               row_in = row_ff + AW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         flag_ff     <= 1'b0;
         dflag_ff    <= 1'b0;
         out_v_ff    <= 1'b0;
         out_last_ff <= 1'b0;
         pvalid_ff   <= '0;
         count_ff    <= COUNT_RESET;
         entry_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         flag_ff     <= flag_in;
         dflag_ff    <= dflag_in;
         out_v_ff    <= out_v_in;
         out_last_ff <= out_last_in;
         pvalid_ff   <= pvalid_in;
         if (csr_wr_en) begin
            if (csr_index == REG_BLOCK_COUNT) begin
               count_ff <= csr_wr_data;
            end else if (csr_index == REG_ENTRY_BLOCK) begin
               entry_ff <= csr_wr_data[LABEL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      scan_ff      <= scan_in;
      prev_ff      <= prev_in;
      changed_ff   <= changed_in;
      rowp_ff      <= rowp_in;
      acc_ff       <= acc_in;
      old_ff       <= old_in;
      member_ff    <= member_in;
      pend_ff      <= pend_in;
      out_lbl_ff   <= out_lbl_in;
      prd_valid_ff <= pvalid_ff[pr_rd_addr];
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = out_v_ff;
   assign rsp_last          = out_last_ff;
   assign rsp_block_label   = LABEL_W'(out_lbl_ff);
   assign rsp_dominator_set = SET_W'(dm_rd_data);
   assign rsp_loop_depth    = dp_rd_data;
endmodule
`default_nettype wire

### hdl/dle_checker.sv
// Port-level checks for the dominator and loop-depth engine, bound to the top.
// Depends on dle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dle_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        busy,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_last,
   input wire logic [dle_pkg::DEPTH_W-1:0] rsp_loop_depth
);
   import dle_pkg::*;

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result beat without a run");

   a_beats_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid) else $error("gap inside result burst");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy) else $error("busy on final beat");

   a_depth_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_loop_depth <= DEPTH_SAT) else $error("loop depth over limit");
endmodule

bind dominator_loop_depth_engine dle_checker u_dle_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_last(rsp_last), .rsp_loop_depth(rsp_loop_depth)
);
`default_nettype wire
